@@ rtl/c_integer_literal_scanner_core_macros.svh @@
// Assertion macros shared by the scanner modules.
// Every module that uses them has a clock i_clk and an active-low reset i_rst_n.
`ifndef C_INTEGER_LITERAL_SCANNER_CORE_MACROS_SVH
`define C_INTEGER_LITERAL_SCANNER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CILS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CILS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cils_pkg.sv @@
// Types and codes of the C integer literal scanner.
// No dependencies; used by every scanner module.
`timescale 1ns / 1ps

package cils_pkg;

    localparam int unsigned VALUE_W = 64;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_INVALID  = 2'd1;
    localparam logic [1:0] ERR_SUFFIX   = 2'd2;
    localparam logic [1:0] ERR_FRACTION = 2'd3;

    localparam logic [1:0] RX_DEC = 2'd0;
    localparam logic [1:0] RX_BIN = 2'd1;
    localparam logic [1:0] RX_OCT = 2'd2;
    localparam logic [1:0] RX_HEX = 2'd3;

    localparam logic [2:0] SF_NONE = 3'd0;
    localparam logic [2:0] SF_L    = 3'd1;
    localparam logic [2:0] SF_LL   = 3'd2;
    localparam logic [2:0] SF_U    = 3'd3;
    localparam logic [2:0] SF_UL   = 3'd4;
    localparam logic [2:0] SF_ULL  = 3'd5;
    localparam logic [2:0] SF_F    = 3'd6;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS,
        PH_SUF_L,
        PH_SUF_LL,
        PH_SUF_U,
        PH_SUF_UL
    } t_phase;

    typedef struct packed {
        logic [7:0] ch;
        logic       at_end;
        logic       start_req;
    } t_in_item;

    typedef struct packed {
        logic               consumed;
        logic               done_res;
        logic [1:0]         error_code;
        logic [VALUE_W-1:0] value;
        logic [2:0]         suffix_code;
        logic [1:0]         radix_code;
    } t_out_item;

    // Classified character as it travels from the front end to the back end.
    // Every character flag is clear at end of input.
    typedef struct packed {
        logic       start;
        logic       eof;
        logic       is_zero;
        logic       is_nz;
        logic       is_hex;
        logic [3:0] digit;
        logic       is_term;
        logic       is_l;
        logic       is_u;
        logic       is_f;
        logic       is_x;
        logic       is_b;
        logic       is_dot;
    } t_cls_item;

endpackage

@@ rtl/cils_queue.sv @@
// Two-entry queue of classified characters between front and back end.
// Depends on cils_pkg and the scanner macro header.
`timescale 1ns / 1ps
`include "c_integer_literal_scanner_core_macros.svh"

module cils_queue
    import cils_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cls_item i_push_item,
    output logic      o_full,
    input  logic      i_pop,
    output t_cls_item o_head,
    output logic      o_empty
);

    localparam int unsigned DEPTH = 2;

    t_cls_item  r_mem [DEPTH];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    assign o_full  = (r_count == 2'(DEPTH));
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    `CILS_ASSERT_NOW(a_no_overflow, i_push, (r_count != 2'(DEPTH)) || i_pop, "queue overflow")
    `CILS_ASSERT_NOW(a_no_underflow, i_pop, r_count != 2'd0, "pop from empty queue")
    `CILS_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 2'd1,
        "queue count did not follow a lone push")

endmodule

@@ rtl/cils_front.sv @@
// Front end: takes input transfers and classifies each character.
// Depends on cils_pkg.
`timescale 1ns / 1ps

module cils_front
    import cils_pkg::*;
(
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    input  logic      i_q_full,
    output logic      o_push,
    output t_cls_item o_push_item
);

    logic [7:0] s_ch;
    logic       s_live;
    logic       s_dec;
    logic       s_lo_af;
    logic       s_up_af;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    assign s_ch    = i_in_item.ch;
    assign s_live  = !i_in_item.at_end;
    assign s_dec   = (s_ch >= "0") && (s_ch <= "9");
    assign s_lo_af = (s_ch >= "a") && (s_ch <= "f");
    assign s_up_af = (s_ch >= "A") && (s_ch <= "F");

    always_comb begin
        o_push_item         = '0;
        o_push_item.start   = i_in_item.start_req;
        o_push_item.eof     = i_in_item.at_end;
        o_push_item.is_zero = s_live && (s_ch == "0");
        o_push_item.is_nz   = s_live && s_dec && (s_ch != "0");
        o_push_item.is_hex  = s_live && (s_dec || s_lo_af || s_up_af);
        // letters a..f and A..F share their low nibble: 1..6
        o_push_item.digit   = s_dec ? s_ch[3:0] : s_ch[3:0] + 4'd9;
        o_push_item.is_term = s_live && ((s_ch == ";") || (s_ch == ")") || (s_ch == "]") ||
                              (s_ch == "}") || (s_ch == " ") || (s_ch == 8'h09) ||
                              (s_ch == 8'h0A) || (s_ch == 8'h0B) || (s_ch == 8'h0C) ||
                              (s_ch == 8'h0D));
        o_push_item.is_l    = s_live && ((s_ch == "l") || (s_ch == "L"));
        o_push_item.is_u    = s_live && ((s_ch == "u") || (s_ch == "U"));
        o_push_item.is_f    = s_live && ((s_ch == "f") || (s_ch == "F"));
        o_push_item.is_x    = s_live && ((s_ch == "x") || (s_ch == "X"));
        o_push_item.is_b    = s_live && ((s_ch == "b") || (s_ch == "B"));
        o_push_item.is_dot  = s_live && (s_ch == ".");
    end

endmodule

@@ rtl/cils_back.sv @@
// Back end: literal state machine, value accumulator and result register.
// Depends on cils_pkg and the scanner macro header.
`timescale 1ns / 1ps
`include "c_integer_literal_scanner_core_macros.svh"

module cils_back
    import cils_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_cls_item i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    typedef struct packed {
        logic       fin;
        logic       cons;
        logic       use_ok;
        logic [1:0] err;
        logic       add;
    } t_act;

    t_phase                r_phase, n_phase;
    logic [VALUE_BITS-1:0] r_accum, n_accum;
    logic [1:0]            r_radix, n_radix;
    logic                  r_bad, n_bad;
    logic [2:0]            r_suffix, n_suffix;
    logic                  r_out_valid;
    t_out_item             r_out, s_res;
    t_act                  s_act;
    logic [1:0]            s_err;

    function automatic logic digit_ok(input logic [1:0] rad, input logic [3:0] d);
        logic ok;
        case (rad)
            RX_DEC:  ok = (d < 4'd10);
            RX_BIN:  ok = (d < 4'd2);
            RX_OCT:  ok = (d < 4'd8);
            RX_HEX:  ok = 1'b1;
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

    // accum * radix + digit as shifts and adds; wraps at VALUE_BITS
    function automatic logic [VALUE_BITS-1:0] mul_add(input logic [VALUE_BITS-1:0] a,
                                                      input logic [1:0] rad,
                                                      input logic [3:0] d);
        logic [VALUE_BITS-1:0] dx;
        logic [VALUE_BITS-1:0] r;
        dx = VALUE_BITS'(d);
        case (rad)
            RX_DEC:  r = (a << 3) + (a << 1) + dx;
            RX_BIN:  r = (a << 1) + dx;
            RX_OCT:  r = (a << 3) + dx;
            RX_HEX:  r = (a << 4) + dx;
            default: r = a;
        endcase
        return r;
    endfunction

    assign o_pop       = !i_q_empty && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_accum  = r_accum;
        n_radix  = r_radix;
        n_bad    = r_bad;
        n_suffix = r_suffix;
        s_act    = '0;

        if (i_head.start) begin
            n_accum  = '0;
            n_radix  = RX_DEC;
            n_bad    = 1'b0;
            n_suffix = SF_NONE;
            n_phase  = PH_IDLE;
            if (i_head.is_zero) begin
                s_act.cons = 1'b1;
                n_phase    = PH_ZERO;
            end else if (i_head.is_nz) begin
                s_act.cons = 1'b1;
                s_act.add  = 1'b1;
                n_phase    = PH_DIGITS;
            end else begin
                s_act.fin = 1'b1;
                s_act.err = ERR_INVALID;
            end
        end else begin
            case (r_phase)
                PH_ZERO: begin
                    if (i_head.eof) begin
                        n_radix   = RX_OCT;
                        s_act.fin = 1'b1;
                        s_act.err = ERR_INVALID;
                    end else if (i_head.is_term) begin
                        s_act.fin    = 1'b1;
                        s_act.use_ok = 1'b1;
                    end else if (i_head.is_f) begin
                        n_suffix     = SF_F;
                        s_act.fin    = 1'b1;
                        s_act.cons   = 1'b1;
                        s_act.use_ok = 1'b1;
                    end else if (i_head.is_u) begin
                        n_suffix   = SF_U;
                        n_phase    = PH_SUF_U;
                        s_act.cons = 1'b1;
                    end else if (i_head.is_l) begin
                        n_suffix   = SF_L;
                        n_phase    = PH_SUF_L;
                        s_act.cons = 1'b1;
                    end else if (i_head.is_x) begin
                        n_radix    = RX_HEX;
                        n_phase    = PH_PREFIX;
                        s_act.cons = 1'b1;
                    end else if (i_head.is_b) begin
                        n_radix    = RX_BIN;
                        n_phase    = PH_PREFIX;
                        s_act.cons = 1'b1;
                    end else if (i_head.is_dot) begin
                        s_act.fin = 1'b1;
                        s_act.err = ERR_FRACTION;
                    end else begin
                        n_radix = RX_OCT;
                        if (i_head.is_hex) begin
                            s_act.add  = 1'b1;
                            s_act.cons = 1'b1;
                            n_phase    = PH_DIGITS;
                        end else begin
                            s_act.fin = 1'b1;
                            s_act.err = ERR_INVALID;
                        end
                    end
                end
                PH_PREFIX: begin
                    if (i_head.is_hex) begin
                        s_act.add  = 1'b1;
                        s_act.cons = 1'b1;
                        n_phase    = PH_DIGITS;
                    end else begin
                        s_act.fin = 1'b1;
                        s_act.err = ERR_INVALID;
                    end
                end
                PH_DIGITS: begin
                    // hex digits come first, so f and b are digits here
                    if (i_head.eof) begin
                        s_act.fin = 1'b1;
                        s_act.err = ERR_INVALID;
                    end else if (i_head.is_hex) begin
                        s_act.add  = 1'b1;
                        s_act.cons = 1'b1;
                    end else if (i_head.is_term) begin
                        s_act.fin    = 1'b1;
                        s_act.use_ok = 1'b1;
                    end else if (i_head.is_u) begin
                        n_suffix   = SF_U;
                        n_phase    = PH_SUF_U;
                        s_act.cons = 1'b1;
                    end else if (i_head.is_l) begin
                        n_suffix   = SF_L;
                        n_phase    = PH_SUF_L;
                        s_act.cons = 1'b1;
                    end else if (i_head.is_dot) begin
                        s_act.fin = 1'b1;
                        s_act.err = ERR_FRACTION;
                    end else begin
                        s_act.fin = 1'b1;
                        s_act.err = ERR_INVALID;
                    end
                end
                PH_SUF_L: begin
                    s_act.use_ok = 1'b1;
                    if (i_head.is_l) begin
                        n_suffix   = SF_LL;
                        n_phase    = PH_SUF_LL;
                        s_act.cons = 1'b1;
                    end else if (i_head.is_u) begin
                        n_suffix   = SF_UL;
                        s_act.fin  = 1'b1;
                        s_act.cons = 1'b1;
                    end else begin
                        s_act.fin = 1'b1;
                    end
                end
                PH_SUF_LL: begin
                    s_act.use_ok = 1'b1;
                    s_act.fin    = 1'b1;
                    if (i_head.is_u) begin
                        n_suffix   = SF_ULL;
                        s_act.cons = 1'b1;
                    end
                end
                PH_SUF_U: begin
                    s_act.use_ok = 1'b1;
                    if (i_head.is_l) begin
                        n_suffix   = SF_UL;
                        n_phase    = PH_SUF_UL;
                        s_act.cons = 1'b1;
                    end else begin
                        s_act.fin = 1'b1;
                    end
                end
                PH_SUF_UL: begin
                    s_act.use_ok = 1'b1;
                    s_act.fin    = 1'b1;
                    if (i_head.is_l) begin
                        n_suffix   = SF_ULL;
                        s_act.cons = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        if (s_act.add) begin
            if (digit_ok(n_radix, i_head.digit)) begin
                n_accum = mul_add(n_accum, n_radix, i_head.digit);
            end else begin
                n_bad = 1'b1;
            end
        end
        if (s_act.fin) begin
            n_phase = PH_IDLE;
        end
    end

    // result of the current step
    always_comb begin
        if (!s_act.use_ok) begin
            s_err = s_act.err;
        end else if (n_suffix == SF_F) begin
            s_err = ERR_SUFFIX;
        end else if (n_bad) begin
            s_err = ERR_INVALID;
        end else begin
            s_err = ERR_NONE;
        end

        s_res          = '0;
        s_res.consumed = s_act.cons;
        if (s_act.fin) begin
            s_res.done_res    = 1'b1;
            s_res.error_code  = s_err;
            s_res.value       = (s_err == ERR_NONE) ? VALUE_W'(n_accum) : '0;
            s_res.suffix_code = n_suffix;
            s_res.radix_code  = n_radix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_accum     <= '0;
            r_radix     <= RX_DEC;
            r_bad       <= 1'b0;
            r_suffix    <= SF_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_accum     <= n_accum;
                r_radix     <= n_radix;
                r_bad       <= n_bad;
                r_suffix    <= n_suffix;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= s_res;
        end
    end

    `CILS_ASSERT_NEXT(a_idle_after_done, o_pop && s_act.fin, r_phase == PH_IDLE,
        "literal not closed after a done result")
    `CILS_ASSERT_NOW(a_pending_is_clear, r_out_valid && !r_out.done_res,
        (r_out.error_code == ERR_NONE) && (r_out.value == '0) &&
        (r_out.suffix_code == SF_NONE) && (r_out.radix_code == RX_DEC),
        "pending result carries data")
    `CILS_ASSERT_NEXT(a_idle_step_empty, o_pop && !i_head.start && (r_phase == PH_IDLE),
        !r_out.consumed && !r_out.done_res, "idle step gave a non-empty result")

endmodule

@@ rtl/c_integer_literal_scanner_core.sv @@
// C integer literal scanner: top level joining front end, queue and back end.
// Depends on cils_pkg, cils_front, cils_queue and cils_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one source
//   character per transfer, with at_end for end of input and start_req on the
//   first character of each literal. Output channel (o_out_valid / i_out_stall
//   / o_out_item) gives exactly one result per input transfer, in order.
//   A character is written into the queue; its result is registered once the
//   back end pops it. Throughput: one character per cycle unless the output
//   stalls; a front-end classify and one accumulator shift-add per character.
//   A two-entry queue separates the front end from the back end and the
//   result register, so input is still taken while a result is stalled.
//   When the receiver stalls, the result holds and the queue fills; once full,
//   o_in_stall rises until the back end drains an entry.
//   Reset (i_rst_n low, synchronous) empties the queue, drops the result and
//   returns the scanner to idle, awaiting a literal start.
`timescale 1ns / 1ps

module c_integer_literal_scanner_core
    import cils_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      s_full;
    logic      s_push;
    t_cls_item s_push_item;
    logic      s_pop;
    logic      s_empty;
    t_cls_item s_head;

    cils_front u_front (
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .i_q_full    (s_full),
        .o_push      (s_push),
        .o_push_item (s_push_item)
    );

    cils_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (s_push),
        .i_push_item (s_push_item),
        .o_full      (s_full),
        .i_pop       (s_pop),
        .o_head      (s_head),
        .o_empty     (s_empty)
    );

    cils_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (s_empty),
        .i_head      (s_head),
        .o_pop       (s_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule
